FILE: design/bwf_pkg.sv
// Shared types, codes, microprogram and arithmetic helpers of the washout filter.
package bwf_pkg;

    localparam int MAX_SLICES_DEF = 31;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN        = 3'd0;
    localparam logic [2:0] REG_INV_DEN     = 3'd1;
    localparam logic [2:0] REG_STORE       = 3'd2;
    localparam logic [2:0] REG_STEP_MODE   = 3'd3;
    localparam logic [2:0] REG_SLICE_CNT   = 3'd4;
    localparam logic [2:0] REG_SLICE_RECIP = 3'd5;
    localparam logic [2:0] REG_GAIN_EN     = 3'd6;

    // Configuration reset values
    localparam logic [31:0] GAIN_RST        = 32'd66;
    localparam logic [4:0]  SLICE_CNT_RST   = 5'd2;
    localparam logic [16:0] SLICE_RECIP_RST = 17'd32768;

    // Item commands
    localparam logic [1:0] CMD_INIT      = 2'd0;
    localparam logic [1:0] CMD_INTEGRATE = 2'd1;
    localparam logic [1:0] CMD_UPDATE    = 2'd2;

    // Step modes; any other code runs as large step
    localparam logic [1:0] STEP_NORMAL = 2'd0;
    localparam logic [1:0] STEP_SMALL  = 2'd1;

    typedef logic [4:0] upc_t;

    // Microprogram entry points and loop head
    localparam upc_t UPC_INIT   = 5'd0;
    localparam upc_t UPC_CLEAR  = 5'd4;
    localparam upc_t UPC_NORMAL = 5'd5;
    localparam upc_t UPC_LARGE  = 5'd9;
    localparam upc_t UPC_UPDATE = 5'd11;
    localparam upc_t UPC_SMALL  = 5'd15;
    localparam upc_t UPC_SLICE  = 5'd18;
    localparam upc_t UPC_NOP    = 5'd24;

    typedef enum logic [1:0] {COEF_A, COEF_C, COEF_D, COEF_R} coef_sel_t;
    typedef enum logic [2:0] {VAL_X, VAL_XI, VAL_S, VAL_T, VAL_DIFF} val_sel_t;
    typedef enum logic [1:0] {ALU_A_Z, ALU_A_ZW, ALU_A_AX, ALU_A_PV} alu_a_sel_t;
    typedef enum logic {ALU_B_PV, ALU_B_S} alu_b_sel_t;
    typedef enum logic [1:0] {S_KEEP, S_PV, S_ZERO} s_op_t;
    typedef enum logic [1:0] {Y_KEEP, Y_ALU, Y_ZERO} y_op_t;
    typedef enum logic [1:0] {Z_KEEP, Z_ALU, Z_ZERO} z_op_t;
    typedef enum logic [1:0] {ZW_KEEP, ZW_LOAD, ZW_ALU} zw_op_t;
    typedef enum logic [1:0] {XI_KEEP, XI_LOAD, XI_ADV} xi_op_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_DONE, SEQ_LOOP} seq_op_t;
    typedef enum logic {SQ_IDLE, SQ_RUN} seq_state_t;

    typedef struct packed {
        coef_sel_t  coef;
        val_sel_t   val;
        logic       mul_en;
        alu_a_sel_t alu_a;
        alu_b_sel_t alu_b;
        logic       alu_sub;
        s_op_t      s_op;
        y_op_t      y_op;
        z_op_t      z_op;
        zw_op_t     zw_op;
        xi_op_t     xi_op;
        logic       ax_wr;
        logic       t_wr;
        logic       step_wr;
        logic       x0_wr;
        logic       cnt_load;
        seq_op_t    seq;
        upc_t       target;
    } uword_t;

    // Control store: one word per step
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        w = '0;
        case (pc)
            // initialize: s = a*x, z = a*x - c*s, y = 0
            5'd0:  begin w.mul_en = 1'b1; w.coef = COEF_A; w.val = VAL_X; end
            5'd1:  begin w.ax_wr = 1'b1; w.s_op = S_PV; end
            5'd2:  begin w.mul_en = 1'b1; w.coef = COEF_C; w.val = VAL_S; end
            5'd3:
            begin
                w.alu_a = ALU_A_AX; w.alu_b = ALU_B_PV; w.alu_sub = 1'b1;
                w.z_op = Z_ALU; w.y_op = Y_ZERO; w.x0_wr = 1'b1; w.seq = SEQ_DONE;
            end
            // initialize with gain off
            5'd4:
            begin
                w.s_op = S_ZERO; w.z_op = Z_ZERO; w.y_op = Y_ZERO;
                w.x0_wr = 1'b1; w.seq = SEQ_DONE;
            end
            // normal integrate
            5'd5:  begin w.mul_en = 1'b1; w.coef = COEF_A; w.val = VAL_X; end
            5'd6:
            begin
                w.ax_wr = 1'b1; w.alu_a = ALU_A_Z; w.alu_b = ALU_B_PV; w.t_wr = 1'b1;
            end
            5'd7:  begin w.mul_en = 1'b1; w.coef = COEF_D; w.val = VAL_T; end
            5'd8:
            begin
                w.s_op = S_PV; w.alu_a = ALU_A_AX; w.alu_b = ALU_B_PV; w.alu_sub = 1'b1;
                w.y_op = Y_ALU; w.seq = SEQ_DONE;
            end
            // large integrate
            5'd9:  begin w.mul_en = 1'b1; w.coef = COEF_A; w.val = VAL_X; end
            5'd10: begin w.s_op = S_PV; w.y_op = Y_ZERO; w.seq = SEQ_DONE; end
            // update
            5'd11: begin w.mul_en = 1'b1; w.coef = COEF_A; w.val = VAL_X; end
            5'd12:
            begin
                w.ax_wr = 1'b1; w.alu_a = ALU_A_PV; w.alu_b = ALU_B_S; w.alu_sub = 1'b1;
                w.y_op = Y_ALU;
            end
            5'd13: begin w.mul_en = 1'b1; w.coef = COEF_C; w.val = VAL_S; end
            5'd14:
            begin
                w.alu_a = ALU_A_AX; w.alu_b = ALU_B_PV; w.alu_sub = 1'b1;
                w.z_op = Z_ALU; w.x0_wr = 1'b1; w.seq = SEQ_DONE;
            end
            // small integrate: prologue
            5'd15:
            begin
                w.mul_en = 1'b1; w.coef = COEF_R; w.val = VAL_DIFF;
                w.xi_op = XI_LOAD; w.zw_op = ZW_LOAD; w.cnt_load = 1'b1;
            end
            5'd16: begin w.step_wr = 1'b1; end
            5'd17: begin w.xi_op = XI_ADV; end
            // small integrate: one slice per pass
            5'd18: begin w.mul_en = 1'b1; w.coef = COEF_A; w.val = VAL_XI; end
            5'd19:
            begin
                w.ax_wr = 1'b1; w.alu_a = ALU_A_ZW; w.alu_b = ALU_B_PV; w.t_wr = 1'b1;
            end
            5'd20: begin w.mul_en = 1'b1; w.coef = COEF_D; w.val = VAL_T; end
            5'd21:
            begin
                w.s_op = S_PV; w.alu_a = ALU_A_AX; w.alu_b = ALU_B_PV; w.alu_sub = 1'b1;
                w.y_op = Y_ALU;
            end
            5'd22: begin w.mul_en = 1'b1; w.coef = COEF_C; w.val = VAL_S; end
            5'd23:
            begin
                w.alu_a = ALU_A_AX; w.alu_b = ALU_B_PV; w.alu_sub = 1'b1;
                w.zw_op = ZW_ALU; w.xi_op = XI_ADV; w.seq = SEQ_LOOP; w.target = UPC_SLICE;
            end
            default: begin w.seq = SEQ_DONE; end
        endcase
        return w;
    endfunction

    // Saturating 32-bit add or subtract
    function automatic logic signed [31:0] sat_add(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic               sub
    );
        logic signed [32:0] r;
        r = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
        if (r[32] != r[31])
            return r[32] ? 32'sh80000000 : 32'sh7fffffff;
        return r[31:0];
    endfunction

endpackage

FILE: design/bwf_sequencer.sv
// Microcode sequencer: step counter, control store, slice counter and dispatch.
module bwf_sequencer
    import bwf_pkg::*;
#(
    parameter int MAX_SLICES = MAX_SLICES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic       gain_enabled,
    input  logic [1:0] step_mode,
    input  logic [4:0] slice_count,
    input  logic       slot_free,
    output uword_t     uw,
    output logic       go,
    output logic       finish
);

    localparam int CNT_W = $clog2(MAX_SLICES + 1);

    seq_state_t       state_reg, state_next;
    upc_t             pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] slice_n;
    upc_t             entry;
    logic             last;

    always_comb
    begin
        if (slice_count == 5'd0)
            slice_n = CNT_W'(1);
        else if (32'(slice_count) > 32'(MAX_SLICES))
            slice_n = CNT_W'(MAX_SLICES);
        else
            slice_n = CNT_W'(slice_count);
    end

    always_comb
    begin
        case (mode)
            CMD_INIT:      entry = gain_enabled ? UPC_INIT : UPC_CLEAR;
            CMD_INTEGRATE:
            begin
                if (!gain_enabled)
                    entry = UPC_NOP;
                else if (step_mode == STEP_SMALL)
                    entry = UPC_SMALL;
                else if (step_mode == STEP_NORMAL)
                    entry = UPC_NORMAL;
                else
                    entry = UPC_LARGE;
            end
            CMD_UPDATE:    entry = gain_enabled ? UPC_UPDATE : UPC_NOP;
            default:       entry = UPC_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            pc_reg    <= UPC_NOP;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        uw       = ucode(pc_reg);
        last     = (uw.seq == SEQ_DONE) ||
                   ((uw.seq == SEQ_LOOP) && (cnt_reg <= CNT_W'(1)));
        in_ready = (state_reg == SQ_IDLE);
        // hold on the final step until the output register is free
        go       = (state_reg == SQ_RUN) && (!last || slot_free);
        finish   = go && last;

        state_next = state_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;

        case (state_reg)
            SQ_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = SQ_RUN;
                    pc_next    = entry;
                end
            end
            SQ_RUN:
            begin
                if (go)
                begin
                    if (last)
                        state_next = SQ_IDLE;
                    else if (uw.seq == SEQ_LOOP)
                        pc_next = uw.target;
                    else
                        pc_next = pc_reg + upc_t'(1);

                    if (uw.cnt_load)
                        cnt_next = slice_n;
                    else if (uw.seq == SEQ_LOOP && !last)
                        cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

endmodule

FILE: design/bilinear_washout_filter.sv
// Washout filter top level: configuration registers, datapath and output register.
// Each item is taken while the sequencer is idle and then run by a short
// microprogram on a datapath with one shared 33x33 multiplier whose product is
// registered before use, so a dependent step waits for that registered product.
// The microprograms are initialize (a clear with gain off), update, normal
// integrate, large integrate, and small integrate, which loops once per slice.
// Gain-off integrate/update and unused commands run only the no-op word. The next
// item is taken as soon as the previous one finishes, even while its result still
// waits in the output register; the final step of a following item holds until that
// register is free. Configuration writes take effect at once and belong to idle time.
module bilinear_washout_filter
    import bwf_pkg::*;
#(
    parameter int MAX_SLICES = MAX_SLICES_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] output_y,
    output logic signed [31:0] state_s
);

    localparam int PROD_W = 66;

    // configuration
    logic signed [31:0] gain_reg, inv_den_reg, store_reg;
    logic [1:0]         step_mode_reg;
    logic [4:0]         slice_cnt_reg;
    logic [16:0]        recip_reg;
    logic               gain_en_reg;

    // datapath
    logic signed [31:0] x_reg;
    logic signed [31:0] s_reg, s_next, z_reg, z_next, x0_reg, x0_next, y_reg, y_next;
    logic signed [31:0] ax_reg, ax_next, t_reg, t_next, zw_reg, zw_next;
    logic signed [31:0] xi_reg, xi_next, step_reg, step_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [31:0] out_y_reg, out_s_reg;
    logic               out_valid_reg;

    logic signed [PROD_W-1:0] prod_sh;
    logic signed [31:0] pv, alu_a, alu_b, alu;
    logic signed [32:0] coef_op, val_op, diff;
    logic               small_step, slot_free, go, finish;
    uword_t             uw;

    assign small_step = (step_mode_reg == STEP_SMALL);
    assign slot_free  = !out_valid_reg || out_ready;

    bwf_sequencer #(
        .MAX_SLICES(MAX_SLICES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .gain_enabled (gain_en_reg),
        .step_mode    (step_mode_reg),
        .slice_count  (slice_cnt_reg),
        .slot_free    (slot_free),
        .uw           (uw),
        .go           (go),
        .finish       (finish)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RST;
            inv_den_reg   <= '0;
            store_reg     <= '0;
            step_mode_reg <= STEP_NORMAL;
            slice_cnt_reg <= SLICE_CNT_RST;
            recip_reg     <= SLICE_RECIP_RST;
            gain_en_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GAIN:        gain_reg      <= cfg_data;
                REG_INV_DEN:     inv_den_reg   <= cfg_data;
                REG_STORE:       store_reg     <= cfg_data;
                REG_STEP_MODE:   step_mode_reg <= cfg_data[1:0];
                REG_SLICE_CNT:   slice_cnt_reg <= cfg_data[4:0];
                REG_SLICE_RECIP: recip_reg     <= cfg_data[16:0];
                REG_GAIN_EN:     gain_en_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Floor-shift the registered product and saturate it to 32 bits
    always_comb
    begin
        prod_sh = prod_reg >>> FRAC_BITS;
        if (prod_sh[PROD_W-1:31] != {(PROD_W-31){prod_sh[PROD_W-1]}})
            pv = prod_sh[PROD_W-1] ? 32'sh80000000 : 32'sh7fffffff;
        else
            pv = prod_sh[31:0];
    end

    always_comb
    begin
        diff = 33'(x_reg) - 33'(x0_reg);

        case (uw.coef)
            COEF_A:  coef_op = 33'(gain_reg);
            COEF_C:  coef_op = 33'(store_reg);
            COEF_D:  coef_op = 33'(inv_den_reg);
            COEF_R:  coef_op = {16'd0, recip_reg};
            default: coef_op = '0;
        endcase

        case (uw.val)
            VAL_X:    val_op = 33'(x_reg);
            VAL_XI:   val_op = 33'(xi_reg);
            VAL_S:    val_op = 33'(s_reg);
            VAL_T:    val_op = 33'(t_reg);
            VAL_DIFF: val_op = diff;
            default:  val_op = '0;
        endcase

        case (uw.alu_a)
            ALU_A_Z:  alu_a = z_reg;
            ALU_A_ZW: alu_a = zw_reg;
            ALU_A_AX: alu_a = ax_reg;
            ALU_A_PV: alu_a = pv;
            default:  alu_a = '0;
        endcase

        alu_b = (uw.alu_b == ALU_B_S) ? s_reg : pv;
        alu   = sat_add(alu_a, alu_b, uw.alu_sub);
    end

    // Next values; every write waits for the step to advance
    always_comb
    begin
        prod_next = prod_reg;
        s_next    = s_reg;
        z_next    = z_reg;
        y_next    = y_reg;
        x0_next   = x0_reg;
        ax_next   = ax_reg;
        t_next    = t_reg;
        zw_next   = zw_reg;
        xi_next   = xi_reg;
        step_next = step_reg;

        if (go)
        begin
            if (uw.mul_en)
                prod_next = coef_op * val_op;

            case (uw.s_op)
                S_PV:    s_next = pv;
                S_ZERO:  s_next = '0;
                default: s_next = s_reg;
            endcase

            case (uw.y_op)
                Y_ALU:   y_next = alu;
                Y_ZERO:  y_next = '0;
                default: y_next = y_reg;
            endcase

            case (uw.z_op)
                Z_ALU:   z_next = alu;
                Z_ZERO:  z_next = '0;
                default: z_next = z_reg;
            endcase

            case (uw.zw_op)
                ZW_LOAD: zw_next = z_reg;
                ZW_ALU:  zw_next = alu;
                default: zw_next = zw_reg;
            endcase

            case (uw.xi_op)
                XI_LOAD: xi_next = x0_reg;
                XI_ADV:  xi_next = sat_add(xi_reg, step_reg, 1'b0);
                default: xi_next = xi_reg;
            endcase

            if (uw.ax_wr)
                ax_next = pv;
            if (uw.t_wr)
                t_next = alu;
            if (uw.step_wr)
                step_next = pv;
            if (uw.x0_wr && small_step)
                x0_next = x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg         <= '0;
            z_reg         <= '0;
            y_reg         <= '0;
            x0_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s_reg  <= s_next;
            z_reg  <= z_next;
            y_reg  <= y_next;
            x0_reg <= x0_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        ax_reg   <= ax_next;
        t_reg    <= t_next;
        zw_reg   <= zw_next;
        xi_reg   <= xi_next;
        step_reg <= step_next;
        if (in_valid && in_ready)
            x_reg <= sample;
        if (finish)
        begin
            out_y_reg <= y_next;
            out_s_reg <= s_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign output_y  = out_y_reg;
    assign state_s   = out_s_reg;

endmodule

FILE: design/bwf_checker.sv
// Port-level checker of the washout filter and its bind to the top level.
module bwf_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         mode,
    input logic signed [31:0] sample,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] output_y,
    input logic signed [31:0] state_s
);

    logic [1:0] pending_reg, pending_next;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // count items taken whose result is not yet transferred
    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
            pending_next = pending_reg + 2'd1;
        else if (!in_xfer && out_xfer)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 2'd0;
        else
            pending_reg <= pending_next;
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(sample))
        else $error("offered item changed or withdrawn before transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(output_y) && $stable(state_s))
        else $error("stalled result changed or dropped");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result shown with no item outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !in_ready)
        else $error("input taken with work and output both occupied");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input ready right after a transfer");

endmodule

bind bilinear_washout_filter bwf_checker u_bwf_checker (.*);

FILE: verif/tb.sv
// Self-checking testbench for the bilinear washout filter.
`timescale 1ns / 100ps

module tb;
    import bwf_pkg::*;

    localparam int          CLK_PERIOD      = 8;
    localparam int          PHASES          = 30;
    localparam int          ITEMS_PER_PHASE = 60;
    localparam int          HOLD_PHASE      = 5;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          TAIL_CYCLES     = 200;
    localparam int unsigned LIMIT_CYCLES    = 2000000;
    localparam int          N_PROBES        = 37;

    localparam logic [1:0] STEP_LARGE     = 2'd2;
    localparam logic [1:0] STEP_LARGE_ALT = 2'd3;
    localparam logic [1:0] CMD_NONE       = 2'd3;

    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] out_y;
        logic signed [31:0] out_s;
    } filter_out_t;

    typedef struct packed {
        logic        is_write;
        logic [2:0]  reg_idx;
        logic [1:0]  cmd;
        logic [31:0] value;
        logic        known;
        logic [31:0] want_y;
        logic [31:0] want_s;
    } probe_row_t;

    typedef enum logic [1:0] {SINK_OPEN, SINK_LOSSY, SINK_MASK, SINK_CHOKED} sink_style_t;

    // Directed rows: register writes, and items with the result typed in where obvious
    localparam probe_row_t PROBES [N_PROBES] = '{
        '{1'b0, REG_GAIN,        CMD_INIT,      32'h00000000, 1'b1, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INIT,      32'h00010000, 1'b1, 32'h0,        32'd66},
        '{1'b0, REG_GAIN,        CMD_INTEGRATE, 32'h00010000, 1'b1, 32'd66,       32'h0},
        '{1'b0, REG_GAIN,        CMD_UPDATE,    32'h00000000, 1'b1, 32'h0,        32'h0},
        '{1'b1, REG_GAIN,        CMD_INIT,      32'h7fffffff, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INIT,      32'h7fffffff, 1'b1, 32'h0,        32'h7fffffff},
        '{1'b0, REG_GAIN,        CMD_INIT,      32'h80000000, 1'b1, 32'h0,        32'h80000000},
        '{1'b0, REG_GAIN,        CMD_UPDATE,    32'h7fffffff, 1'b1, 32'h7fffffff, 32'h80000000},
        '{1'b0, REG_GAIN,        CMD_INTEGRATE, 32'h80000000, 1'b1, 32'h80000000, 32'h0},
        '{1'b1, REG_GAIN_EN,     CMD_INIT,      32'h00000000, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INIT,      32'h00003039, 1'b1, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INTEGRATE, 32'h7fffffff, 1'b1, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_UPDATE,    32'h80000000, 1'b1, 32'h0,        32'h0},
        '{1'b1, REG_GAIN_EN,     CMD_INIT,      32'h00000001, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_NONE,      32'h0000022b, 1'b1, 32'h0,        32'h0},
        '{1'b1, REG_GAIN,        CMD_INIT,      32'h00018000, 1'b0, 32'h0,        32'h0},
        '{1'b1, REG_INV_DEN,     CMD_INIT,      32'h00004000, 1'b0, 32'h0,        32'h0},
        '{1'b1, REG_STORE,       CMD_INIT,      32'hffff0000, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INIT,      32'h00020000, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INTEGRATE, 32'hfffe0000, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_UPDATE,    32'h00010000, 1'b0, 32'h0,        32'h0},
        '{1'b1, REG_STEP_MODE,   CMD_INIT,      {30'd0, STEP_SMALL}, 1'b0, 32'h0, 32'h0},
        '{1'b1, REG_SLICE_CNT,   CMD_INIT,      32'h00000000, 1'b0, 32'h0,        32'h0},
        '{1'b1, REG_SLICE_RECIP, CMD_INIT,      32'h0001ffff, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INIT,      32'h00010000, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INTEGRATE, 32'h00050000, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_UPDATE,    32'h7fffffff, 1'b0, 32'h0,        32'h0},
        '{1'b1, REG_SLICE_CNT,   CMD_INIT,      32'd31,       1'b0, 32'h0,        32'h0},
        '{1'b1, REG_SLICE_RECIP, CMD_INIT,      32'd2114,     1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INTEGRATE, 32'h80000000, 1'b0, 32'h0,        32'h0},
        '{1'b1, REG_STEP_MODE,   CMD_INIT,      {30'd0, STEP_LARGE}, 1'b0, 32'h0, 32'h0},
        '{1'b0, REG_GAIN,        CMD_INIT,      32'h00030000, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_INTEGRATE, 32'h00040000, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_UPDATE,    32'hffff8000, 1'b0, 32'h0,        32'h0},
        '{1'b1, REG_STEP_MODE,   CMD_INIT,      {30'd0, STEP_LARGE_ALT}, 1'b0, 32'h0, 32'h0},
        '{1'b0, REG_GAIN,        CMD_INTEGRATE, 32'h00010000, 1'b0, 32'h0,        32'h0},
        '{1'b0, REG_GAIN,        CMD_UPDATE,    32'h00020000, 1'b0, 32'h0,        32'h0}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_addr;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic signed [31:0] sample;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] output_y;
    logic signed [31:0] state_s;

    // Filter model: configuration and state
    longint     gain_k;
    longint     inv_den;
    longint     store_c;
    logic [1:0] step_sel;
    logic [4:0] slice_n;
    longint     recip_q;
    logic       gain_on;
    longint     flt_s;
    longint     flt_z;
    longint     flt_x0;
    longint     flt_y;

    filter_out_t pending_out [$];
    logic [1:0]  next_cmd;
    int          hold_asked;
    int          holds_done;
    int          fail_count;
    int          items_sent;
    int          results_checked;
    int          reg_writes;
    int          mode_hits [4];
    int unsigned cycle_count;

    bilinear_washout_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .output_y  (output_y),
        .state_s   (state_s)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint clamp32(input longint v);
        if (v > S32_HI)
            return S32_HI;
        if (v < S32_LO)
            return S32_LO;
        return v;
    endfunction

    // Exact product, floor shift, saturate
    function automatic longint qmul(input longint p, input longint q);
        longint prod;
        prod = p * q;
        return clamp32(prod >>> FRAC_BITS_DEF);
    endfunction

    function automatic filter_out_t advance_filter(input logic [1:0] cmd,
                                                   input logic signed [31:0] x_in);
        longint      x;
        longint      ax;
        longint      stp;
        longint      xi;
        longint      zw;
        longint      si;
        longint      yi;
        int          n;
        logic        sub_sliced;
        logic        one_shot;
        filter_out_t r;
        x = x_in;
        sub_sliced = (step_sel == STEP_SMALL);
        one_shot = (step_sel == STEP_LARGE) || (step_sel == STEP_LARGE_ALT);
        if (cmd == CMD_INIT)
        begin
            if (gain_on)
            begin
                ax = qmul(gain_k, x);
                flt_s = ax;
                flt_z = clamp32(ax - qmul(store_c, flt_s));
            end
            else
            begin
                flt_s = 0;
                flt_z = 0;
            end
            flt_y = 0;
            if (sub_sliced)
                flt_x0 = x;
        end
        else if (cmd == CMD_INTEGRATE && gain_on)
        begin
            if (sub_sliced)
            begin
                // walk from the old input toward x; the store itself is left alone
                stp = qmul(x - flt_x0, recip_q);
                xi = flt_x0;
                zw = flt_z;
                si = 0;
                yi = 0;
                n = slice_n;
                if (n < 1)
                    n = 1;
                if (n > MAX_SLICES_DEF)
                    n = MAX_SLICES_DEF;
                for (int i = 0; i < n; i++)
                begin
                    xi = clamp32(xi + stp);
                    ax = qmul(gain_k, xi);
                    si = qmul(clamp32(zw + ax), inv_den);
                    yi = clamp32(ax - si);
                    zw = clamp32(ax - qmul(store_c, si));
                end
                flt_s = si;
                flt_y = yi;
            end
            else if (one_shot)
            begin
                flt_s = qmul(gain_k, x);
                flt_y = 0;
            end
            else
            begin
                ax = qmul(gain_k, x);
                flt_s = qmul(clamp32(flt_z + ax), inv_den);
                flt_y = clamp32(ax - flt_s);
            end
        end
        else if (cmd == CMD_UPDATE && gain_on)
        begin
            ax = qmul(gain_k, x);
            flt_y = clamp32(ax - flt_s);
            flt_z = clamp32(ax - qmul(store_c, flt_s));
            if (sub_sliced)
                flt_x0 = x;
        end
        r.out_y = flt_y[31:0];
        r.out_s = flt_s[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3, 4: return $signed($urandom());
            default: return $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000;
        endcase
    endfunction

    // Mostly integrate/update pairs; now and then a restart, a repeat or a dead code
    function automatic logic [1:0] pick_command();
        int         roll;
        logic [1:0] c;
        roll = $urandom_range(0, 39);
        if (roll == 0)
            return CMD_NONE;
        if (roll < 3)
        begin
            next_cmd = CMD_INTEGRATE;
            return CMD_INIT;
        end
        if (roll < 5)
            return (next_cmd == CMD_INTEGRATE) ? CMD_UPDATE : CMD_INTEGRATE;
        c = next_cmd;
        next_cmd = (c == CMD_INTEGRATE) ? CMD_UPDATE : CMD_INTEGRATE;
        return c;
    endfunction

    function automatic logic [31:0] pick_coef(input int span);
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom();
            default: return 32'($urandom_range(0, 2 * span)) - 32'(span);
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GAIN:        gain_k = longint'($signed(val));
            REG_INV_DEN:     inv_den = longint'($signed(val));
            REG_STORE:       store_c = longint'($signed(val));
            REG_STEP_MODE:   step_sel = val[1:0];
            REG_SLICE_CNT:   slice_n = val[4:0];
            REG_SLICE_RECIP: recip_q = longint'(val[16:0]);
            REG_GAIN_EN:     gain_on = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Drop valid and hold it low; the argument n gives the length of the rest
    task automatic rest_input(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic drain_results();
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] x,
                             input logic use_typed, input filter_out_t typed);
        filter_out_t predicted;
        @(negedge clk);
        in_valid <= 1'b1;
        mode <= cmd;
        sample <= x;
        do
            @(posedge clk);
        while (!in_ready);
        mode_hits[step_sel]++;
        predicted = advance_filter(cmd, x);
        pending_out.push_back(use_typed ? typed : predicted);
        items_sent++;
    endtask

    task automatic configure_phase(input int ph);
        logic [1:0]  stp;
        logic [4:0]  cnt;
        logic [16:0] rcp;
        logic [31:0] junk;
        stp = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0: cnt = 5'd0;
            1: cnt = 5'd31;
            2: cnt = 5'd1;
            default: cnt = 5'($urandom_range(2, 6));
        endcase
        case ($urandom_range(0, 5))
            0: rcp = 17'd0;
            1: rcp = 17'h1ffff;
            default: rcp = (cnt == 0) ? 17'd65536 : 17'(65536 / cnt);
        endcase
        junk = $urandom();
        write_reg(REG_GAIN, pick_coef(32'h00080000));
        write_reg(REG_INV_DEN, pick_coef(32'h00010000));
        write_reg(REG_STORE, pick_coef(32'h00100000));
        // upper bits of the narrow registers carry junk
        write_reg(REG_STEP_MODE, {junk[31:2], stp});
        write_reg(REG_SLICE_CNT, {junk[31:5], cnt});
        write_reg(REG_SLICE_RECIP, {junk[31:17], rcp});
        write_reg(REG_GAIN_EN, {junk[31:1], ($urandom_range(0, 5) != 0)});
    endtask

    task automatic run_items(input int count, input logic steady);
        int burst;
        burst = $urandom_range(1, 16);
        for (int k = 0; k < count; k++)
        begin
            send_item(pick_command(), pick_sample(), 1'b0, '0);
            burst--;
            if (burst == 0)
            begin
                if (!steady && $urandom_range(0, 2) != 0)
                    rest_input($urandom_range(1, 12));
                burst = $urandom_range(1, 24);
            end
        end
        rest_input(1);
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_GAIN;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = CMD_INIT;
        sample = '0;
        hold_asked = 0;
        items_sent = 0;
        reg_writes = 0;
        next_cmd = CMD_INIT;
        mode_hits = '{0, 0, 0, 0};
        gain_k = longint'($signed(GAIN_RST));
        inv_den = 0;
        store_c = 0;
        step_sel = STEP_NORMAL;
        slice_n = SLICE_CNT_RST;
        recip_q = longint'(SLICE_RECIP_RST);
        gain_on = 1'b1;
        flt_s = 0;
        flt_z = 0;
        flt_x0 = 0;
        flt_y = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_PROBES; i++)
        begin
            if (PROBES[i].is_write)
            begin
                rest_input(1);
                drain_results();
                write_reg(PROBES[i].reg_idx, PROBES[i].value);
            end
            else
            begin
                send_item(PROBES[i].cmd, PROBES[i].value, PROBES[i].known,
                          {PROBES[i].want_y, PROBES[i].want_s});
                if ($urandom_range(0, 1) != 0)
                    rest_input($urandom_range(1, 3));
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            rest_input(1);
            drain_results();
            configure_phase(ph);
            next_cmd = CMD_INIT;
            // keep offering while the sink holds off, so the input backs up
            if (ph == HOLD_PHASE)
                hold_asked++;
            run_items(ITEMS_PER_PHASE, ph == HOLD_PHASE);
        end

        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d items sent, %0d results checked, %0d register writes, %0d long hold",
                 items_sent, results_checked, reg_writes, holds_done);
        $display("tb: items by step mode normal/small/large/alt %0d/%0d/%0d/%0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : result_sink
        int          seg_len;
        sink_style_t style;
        logic [7:0]  mask;
        holds_done = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_asked != holds_done)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end
            else
            begin
                seg_len = $urandom_range(16, 160);
                style = sink_style_t'($urandom_range(0, 3));
                mask = $urandom();
                for (int k = 0; k < seg_len && hold_asked == holds_done; k++)
                begin
                    @(negedge clk);
                    case (style)
                        SINK_OPEN:  out_ready <= 1'b1;
                        SINK_LOSSY: out_ready <= ($urandom_range(0, 3) != 0);
                        SINK_MASK:  out_ready <= mask[k % 8];
                        default:    out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        fail_count = 0;
        results_checked = 0;
    end

    always @(posedge clk)
    begin : result_check
        filter_out_t head;
        if (rst_n === 1'b1 && out_valid && out_ready)
        begin
            if (pending_out.size() == 0)
            begin
                $error("unexpected transfer: output_y %0d, state_s %0d", output_y, state_s);
                fail_count++;
            end
            else
            begin
                head = pending_out.pop_front();
                results_checked++;
                if (head.out_y !== output_y)
                begin
                    $error("output_y: expected %0d, got %0d", head.out_y, output_y);
                    fail_count++;
                end
                if (head.out_s !== state_s)
                begin
                    $error("state_s: expected %0d, got %0d", head.out_s, state_s);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $error("timeout with %0d results outstanding", pending_out.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
        cycle_count = 0;

endmodule

FILE: filelist.f
design/bwf_pkg.sv
design/bwf_sequencer.sv
design/bilinear_washout_filter.sv
design/bwf_checker.sv
verif/tb.sv
